/* sv/rau_pkg.sv */
package rau_pkg;

    localparam int OperandWidth = 16;
    localparam int NumOutWidth  = 33;
    localparam int DenOutWidth  = 31;
    localparam int ProdWidth    = 2 * OperandWidth;
    localparam int RawWidth     = ProdWidth + 2;
    localparam int MagWidth     = ProdWidth + 1;
    localparam int IterWidth    = $clog2(MagWidth + 1);
    localparam int QueueDepth   = 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_ZERO_DEN = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] first_numerator;
        logic signed [15:0] first_denominator;
        logic signed [15:0] second_numerator;
        logic signed [15:0] second_denominator;
    } t_in_item;

    typedef struct packed {
        logic signed [NumOutWidth-1:0] result_numerator;
        logic [DenOutWidth-1:0]        result_denominator;
        logic [1:0]                    status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                     status;
        logic                           neg;
        logic [MagWidth-1:0]            num_mag;
        logic [MagWidth-1:0]            den_mag;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

/* sv/rau_front.sv */
module rau_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  rau_pkg::t_in_item i_item,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output rau_pkg::t_job    o_job
);
    import rau_pkg::*;

    logic                        r_s1_valid;
    logic [1:0]                  r_s1_cmd;
    logic [1:0]                  r_s1_status;
    logic signed [ProdWidth-1:0] r_p0, r_p1, r_p2;
    logic                        r_s2_valid;
    t_job                        r_s2_job;

    logic signed [OperandWidth-1:0] w_na, w_da, w_nb, w_db;
    logic signed [OperandWidth-1:0] w_m0a, w_m0b, w_m1a, w_m1b, w_m2a, w_m2b;
    logic [1:0]                     w_status;
    logic signed [RawWidth-1:0]     w_num, w_den;
    logic                           w_s2_free, w_s1_free;
    t_job                           w_job;

    assign w_na = i_item.first_numerator[OperandWidth-1:0];
    assign w_da = i_item.first_denominator[OperandWidth-1:0];
    assign w_nb = i_item.second_numerator[OperandWidth-1:0];
    assign w_db = i_item.second_denominator[OperandWidth-1:0];

    always_comb begin
        w_m0a = w_na;
        w_m0b = w_db;
        w_m1a = w_da;
        w_m1b = w_nb;
        w_m2a = w_da;
        w_m2b = w_db;
        if (i_item.command == CMD_MUL) begin
            w_m0b = w_nb;
        end else if (i_item.command == CMD_DIV) begin
            w_m2b = w_nb;
        end
        if (w_da == '0 || w_db == '0) begin
            w_status = STATUS_ZERO_DEN;
        end else if (i_item.command == CMD_DIV && w_nb == '0) begin
            w_status = STATUS_DIV_ZERO;
        end else begin
            w_status = STATUS_OK;
        end
    end

    always_comb begin
        case (r_s1_cmd)
            CMD_ADD: w_num = RawWidth'(r_p0) + RawWidth'(r_p1);
            CMD_SUB: w_num = RawWidth'(r_p0) - RawWidth'(r_p1);
            default: w_num = RawWidth'(r_p0);
        endcase
        w_den = RawWidth'(r_p2);
        if (w_den < 0) begin
            w_num = -w_num;
            w_den = -w_den;
        end
        w_job.status  = r_s1_status;
        w_job.neg     = w_num[RawWidth-1];
        w_job.num_mag = w_num[RawWidth-1] ? MagWidth'(-w_num) : MagWidth'(w_num);
        w_job.den_mag = MagWidth'(w_den);
        if (r_s1_status != STATUS_OK) begin
            w_job.neg     = 1'b0;
            w_job.num_mag = '0;
            w_job.den_mag = '0;
        end
    end

    assign w_s2_free = !r_s2_valid || i_job_ready;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign o_full    = !w_s1_free;

    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1_cmd    <= i_item.command;
            r_s1_status <= w_status;
            r_p0        <= w_m0a * w_m0b;
            r_p1        <= w_m1a * w_m1b;
            r_p2        <= w_m2a * w_m2b;
        end
        if (w_s2_free && r_s1_valid) begin
            r_s2_job <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_push;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    assign o_job_valid = r_s2_valid;
    assign o_job       = r_s2_job;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !i_job_ready |=> r_s2_valid && $stable(r_s2_job))
        else $error("job dropped while stalled");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_job.status != STATUS_OK |-> r_s2_job.den_mag == '0)
        else $error("error job carries data");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_job.status == STATUS_OK |-> r_s2_job.den_mag != '0)
        else $error("ok job with zero denominator");
endmodule

/* sv/rau_queue.sv */
module rau_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rau_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output rau_pkg::t_job o_job
);
    import rau_pkg::*;

    localparam int PtrWidth = $clog2(QueueDepth);

    t_job                  r_mem [QueueDepth];
    logic [PtrWidth-1:0]   r_wr, r_rd;
    logic [PtrWidth:0]     r_count;
    logic                  w_push, w_pop;

    assign o_ready = r_count != (PtrWidth+1)'(QueueDepth);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (PtrWidth+1)'(w_push) - (PtrWidth+1)'(w_pop);
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PtrWidth+1)'(QueueDepth))
        else $error("queue overflow");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr == r_rd)
        else $error("empty queue with pointer gap");
endmodule

/* sv/rau_back.sv */
module rau_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  rau_pkg::t_job     i_job,
    output logic              o_empty,
    input  logic              i_pop,
    output rau_pkg::t_out_item o_item
);
    import rau_pkg::*;

    t_back_state           r_state, n_state;
    t_job                  r_job;
    logic [MagWidth-1:0]   r_x, r_y;
    logic [MagWidth-1:0]   r_rem, r_quo_n, r_quo_d, r_dn, r_dd;
    logic [IterWidth-1:0]  r_bit;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic [MagWidth:0]     w_tn, w_td;
    logic [MagWidth-1:0]   w_g;
    logic [MagWidth-1:0]   w_rn, w_rd;
    logic                  w_load, w_fin;
    logic [MagWidth:0]     w_signed_num;

    assign o_job_ready = r_state == ST_IDLE;
    assign w_load      = i_job_valid && o_job_ready;
    assign w_fin       = r_state == ST_DONE && (!r_out_valid || i_pop);

    // one restoring-division bit per cycle for numerator and denominator
    assign w_g  = r_x;
    assign w_tn = {r_dn, r_job.num_mag[r_bit]};
    assign w_td = {r_dd, r_job.den_mag[r_bit]};
    assign w_rn = (w_tn >= {1'b0, w_g}) ? MagWidth'(w_tn - {1'b0, w_g}) : w_tn[MagWidth-1:0];
    assign w_rd = (w_td >= {1'b0, w_g}) ? MagWidth'(w_td - {1'b0, w_g}) : w_td[MagWidth-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (r_job.num_mag == '0) begin
                    n_state = ST_DONE;
                end else if (r_x == r_y) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    r_job   <= i_job;
                    r_x     <= i_job.num_mag;
                    r_y     <= i_job.den_mag;
                    r_quo_n <= i_job.num_mag;
                    r_quo_d <= i_job.den_mag;
                end
            end
            ST_GCD: begin
                if (r_x > r_y) begin
                    r_x <= r_x - r_y;
                end else if (r_y > r_x) begin
                    r_y <= r_y - r_x;
                end
                r_dn  <= '0;
                r_dd  <= '0;
                r_bit <= IterWidth'(MagWidth - 1);
            end
            ST_DIV: begin
                r_dn       <= w_rn;
                r_dd       <= w_rd;
                r_quo_n    <= {r_quo_n[MagWidth-2:0], w_tn >= {1'b0, w_g}};
                r_quo_d    <= {r_quo_d[MagWidth-2:0], w_td >= {1'b0, w_g}};
                r_bit      <= r_bit - 1'b1;
            end
            default: begin
            end
        endcase
        r_rem <= r_x;
    end

    assign w_signed_num = r_job.neg ? -{1'b0, r_quo_n} : {1'b0, r_quo_n};

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out.result_numerator   <= NumOutWidth'(w_signed_num);
            r_out.result_denominator <= DenOutWidth'(r_quo_d);
            r_out.status             <= r_job.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    a_gcd_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_x != '0 && r_rem == r_x)
        else $error("zero divisor in reduction");
    a_div_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && r_job.num_mag != '0 && $past(r_state) == ST_DIV
        |-> r_dn == '0 && r_dd == '0)
        else $error("reduction left a remainder");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out))
        else $error("result changed while waiting");
endmodule

/* sv/rational_arith_unit.sv */
// Rational arithmetic on two signed 16-bit fractions: add, subtract, multiply or divide,
// result reduced to lowest terms with a positive denominator (zero numerator unreduced).
// A two-stage front forms the cross products and flags a zero input denominator (status 2)
// or a divide by a zero fraction (status 1, both result fields 0); a two-entry queue feeds
// the back end, which finds the gcd by repeated subtraction, one step a cycle, then
// divides both terms by it, one quotient bit a cycle. The number of gcd steps depends
// on the data; items are handled one at a time in the back end, and the front keeps
// accepting until the queue and both front stages are full.
module rational_arith_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rau_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output rau_pkg::t_out_item o_item
);
    import rau_pkg::*;

    logic f_valid, f_ready, q_valid, q_ready;
    t_job f_job, q_job;

    rau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_job_valid(f_valid),
        .i_job_ready(f_ready),
        .o_job      (f_job)
    );

    rau_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_ready(f_ready),
        .i_job  (f_job),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_job  (q_job)
    );

    rau_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(q_valid),
        .o_job_ready(q_ready),
        .i_job      (q_job),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_item     (o_item)
    );
endmodule

/* verif/tb_rational_arith_unit.sv */
module tb_rational_arith_unit;
    import rau_pkg::*;

    localparam int NumRandom  = 2000;
    localparam int PauseAt    = 900;
    localparam int CycleLimit = 40000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_item;

    t_in_item  pending_items[$];
    t_out_item expected_fractions[$];
    int        sent;
    int        checked;
    int        errors;
    int        cycles;
    int        send_gap;
    int        pop_gap;
    bit        pause_done;
    int        cmd_count[4];
    int        status_count[3];

    rational_arith_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out_item reduce_fraction(t_in_item it);
        t_out_item r;
        longint    na;
        longint    da;
        longint    nb;
        longint    db;
        longint    num;
        longint    den;
        longint    x;
        longint    y;
        longint    t;
        na = longint'(it.first_numerator);
        da = longint'(it.first_denominator);
        nb = longint'(it.second_numerator);
        db = longint'(it.second_denominator);
        r = '0;
        if (da == 0 || db == 0) begin
            r.status = STATUS_ZERO_DEN;
            return r;
        end
        if (t_cmd'(it.command) == CMD_DIV && nb == 0) begin
            r.status = STATUS_DIV_ZERO;
            return r;
        end
        case (t_cmd'(it.command))
            CMD_ADD: begin
                num = na * db + da * nb;
                den = da * db;
            end
            CMD_SUB: begin
                num = na * db - da * nb;
                den = da * db;
            end
            CMD_MUL: begin
                num = na * nb;
                den = da * db;
            end
            default: begin
                num = na * db;
                den = da * nb;
            end
        endcase
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num != 0) begin
            x = (num < 0) ? -num : num;
            y = den;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            num = num / x;
            den = den / x;
        end
        r.result_numerator   = num[NumOutWidth-1:0];
        r.result_denominator = den[DenOutWidth-1:0];
        r.status             = STATUS_OK;
        return r;
    endfunction

    function automatic t_in_item mk(t_cmd c, int na, int da, int nb, int db);
        t_in_item it;
        it.command            = c;
        it.first_numerator    = 16'(na);
        it.first_denominator  = 16'(da);
        it.second_numerator   = 16'(nb);
        it.second_denominator = 16'(db);
        return it;
    endfunction

    function automatic int small_val(bit nonzero);
        int v;
        v = int'($urandom_range(0, 120)) - 60;
        if (nonzero && v == 0)
            v = 1;
        return v;
    endfunction

    // operand values kept so the gcd subtraction count stays modest
    function automatic t_in_item random_item();
        t_in_item it;
        t_cmd     c;
        int       kind;
        int       sh;
        int       x;
        c = t_cmd'($urandom_range(0, 3));
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            it = t_in_item'({$urandom(), $urandom(), $urandom()});
            if ($urandom_range(0, 1))
                it.first_denominator = '0;
            else
                it.second_denominator = '0;
        end else if (kind < 50) begin
            it = mk(c, small_val(0), small_val(1), small_val(0), small_val(1));
        end else if (kind < 75) begin
            sh = $urandom_range(0, 9);
            it = mk(c, small_val(0) <<< sh, small_val(1) <<< sh,
                    small_val(0) <<< sh, small_val(1) <<< sh);
        end else begin
            x = int'($urandom_range(0, 65535)) - 32768;
            if (x == 0)
                x = -32768;
            if ($urandom_range(0, 1))
                it = mk(c, x, x, small_val(0), small_val(1));
            else
                it = mk(c, small_val(0), small_val(1), x, x);
        end
        if ($urandom_range(0, 30) == 0 && it.command == CMD_DIV)
            it.second_numerator = '0;
        return it;
    endfunction

    function automatic int draw_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_item  = '0;
        pending_items.push_back(mk(CMD_ADD, 1, 2, 1, 3));
        pending_items.push_back(mk(CMD_SUB, 1, 2, 1, 2));
        pending_items.push_back(mk(CMD_MUL, 0, 5, 3, 7));
        pending_items.push_back(mk(CMD_DIV, 2, 3, -4, 9));
        pending_items.push_back(mk(CMD_ADD, 32767, 32767, 32767, 32767));
        pending_items.push_back(mk(CMD_SUB, -32768, -32768, 32767, 32767));
        pending_items.push_back(mk(CMD_MUL, -32768, -32768, -32768, -32768));
        pending_items.push_back(mk(CMD_DIV, -32768, 32767, -32768, 32767));
        pending_items.push_back(mk(CMD_MUL, -1, -1, -1, -1));
        pending_items.push_back(mk(CMD_ADD, 5, -7, 3, 14));
        pending_items.push_back(mk(CMD_DIV, 7, 9, 0, 5));
        pending_items.push_back(mk(CMD_DIV, -32768, -1, 0, -32768));
        pending_items.push_back(mk(CMD_ADD, 3, 0, 1, 2));
        pending_items.push_back(mk(CMD_DIV, 3, 4, 0, 0));
        pending_items.push_back(mk(CMD_MUL, 32767, 32767, 1, 0));
        pending_items.push_back(mk(CMD_SUB, 0, 5, 0, 7));
        pending_items.push_back(mk(CMD_ADD, 0, -5, 0, 7));
        pending_items.push_back(mk(CMD_DIV, 0, 3, 2, -5));
        pending_items.push_back(mk(CMD_MUL, 16384, 16384, -16384, 16384));
        pending_items.push_back(mk(CMD_SUB, 4, -6, -4, 6));
        for (int i = 0; i < NumRandom; i++)
            pending_items.push_back(random_item());
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !push);
        wait (expected_fractions.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("%0d transfers in, %0d results checked, %0d errors", sent, checked, errors);
        $display("commands add/sub/mul/div %0d/%0d/%0d/%0d, status ok/div0/zden %0d/%0d/%0d",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
                 status_count[0], status_count[1], status_count[2]);
        if (errors == 0 && expected_fractions.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_fractions.push_back(reduce_fraction(i_item));
                cmd_count[i_item.command]++;
                sent++;
            end
            if (!(push && full)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (!pause_done && sent == PauseAt && expected_fractions.size() != 0) begin
                    push <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    if (sent == PauseAt)
                        pause_done = 1'b1;
                    i_item   <= pending_items.pop_front();
                    push     <= 1'b1;
                    send_gap = draw_gap();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                checked++;
                if (expected_fractions.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, o_item);
                end else begin
                    want = expected_fractions.pop_front();
                    if (o_item.status < 3)
                        status_count[o_item.status]++;
                    if (o_item.result_numerator !== want.result_numerator) begin
                        errors++;
                        $display("%0t: numerator expected %0d actual %0d", $time,
                                 want.result_numerator, o_item.result_numerator);
                    end
                    if (o_item.result_denominator !== want.result_denominator) begin
                        errors++;
                        $display("%0t: denominator expected %0d actual %0d", $time,
                                 want.result_denominator, o_item.result_denominator);
                    end
                    if (o_item.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_item.status);
                    end
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop     <= 1'b1;
                pop_gap = draw_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_fractions.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
